/* src/cgd_pkg.sv */
// ============================================================================
// cgd_pkg - CELP gain decoder shared types, constants and tables
// Gain codebooks, index maps, MA predictor taps and log2/pow2 tables.
// ============================================================================
package cgd_pkg;

	// shared multiplier operand and product types
	typedef logic signed [23:0] mul_a_t;
	typedef logic signed [15:0] mul_b_t;
	typedef logic signed [39:0] mul_p_t;

	// payload types
	typedef logic signed [15:0] s16_t;
	typedef logic        [14:0] u15_t;
	typedef logic signed [7:0]  s8_t;

	// constants
	localparam s16_t   ERR_DEFAULT  = -16'sd14336;
	localparam mul_b_t DB_PER_LOG2  = 16'sd24660;
	localparam mul_b_t NEG_DB_LOG2  = -16'sd24660;
	localparam mul_b_t INV_DB_SCALE = 16'sd5439;
	localparam mul_p_t EC_BAR_BIAS  = 40'sd2085632;
	localparam logic signed [16:0] ERASE_DECAY = 17'sd4096;
	localparam logic [30:0] ENERGY_MAX = 31'h7FFF_FFFF;
	localparam u15_t   Q1_MAX       = 15'h7FFF;

	// codebook index maps
	localparam logic [2:0] MAP_A [8] = '{3'd5, 3'd1, 3'd7, 3'd4, 3'd2, 3'd0, 3'd6, 3'd3};
	localparam logic [3:0] MAP_B [16] = '{4'd2, 4'd14, 4'd3, 4'd13, 4'd0, 4'd15, 4'd1, 4'd12,
		4'd6, 4'd10, 4'd7, 4'd9, 4'd4, 4'd11, 4'd5, 4'd8};

	// first stage: pitch part and fixed-gain factor part
	localparam s16_t STAGE1_GP [8] = '{16'sd1, 16'sd1551, 16'sd1831, 16'sd57,
		16'sd1921, 16'sd3242, 16'sd356, 16'sd2678};
	localparam s16_t STAGE1_GC [8] = '{16'sd1516, 16'sd2425, 16'sd5022, 16'sd5404,
		16'sd9291, 16'sd9949, 16'sd14756, 16'sd27162};

	// second stage
	localparam s16_t STAGE2_GP [16] = '{16'sd826, 16'sd1994, 16'sd5142, 16'sd6160,
		16'sd8091, 16'sd9120, 16'sd10573, 16'sd11928, 16'sd12592, 16'sd13432,
		16'sd14222, 16'sd15030, 16'sd15872, 16'sd16799, 16'sd17932, 16'sd19426};
	localparam s16_t STAGE2_GC [16] = '{16'sd2005, 16'sd0, 16'sd592, 16'sd845,
		16'sd1761, 16'sd2395, 16'sd2801, 16'sd3152, 16'sd3692, 16'sd3927,
		16'sd4407, 16'sd4928, 16'sd5503, 16'sd6131, 16'sd7055, 16'sd8571};

	// MA predictor taps
	localparam mul_b_t MA_COEF [4] = '{16'sd5571, 16'sd4751, 16'sd2785, 16'sd1556};

	// interpolation tables, 32 segments plus end point
	localparam u15_t LOG2_LUT [33] = '{15'd0, 15'd1455, 15'd2866, 15'd4236, 15'd5568,
		15'd6863, 15'd8124, 15'd9352, 15'd10549, 15'd11716, 15'd12855, 15'd13967,
		15'd15054, 15'd16117, 15'd17156, 15'd18172, 15'd19167, 15'd20142, 15'd21097,
		15'd22033, 15'd22951, 15'd23852, 15'd24735, 15'd25603, 15'd26455, 15'd27291,
		15'd28113, 15'd28922, 15'd29716, 15'd30497, 15'd31266, 15'd32023, 15'd32767};
	localparam u15_t POW2_LUT [33] = '{15'd16384, 15'd16743, 15'd17109, 15'd17484,
		15'd17867, 15'd18258, 15'd18658, 15'd19066, 15'd19484, 15'd19911, 15'd20347,
		15'd20792, 15'd21247, 15'd21713, 15'd22188, 15'd22674, 15'd23170, 15'd23678,
		15'd24196, 15'd24726, 15'd25268, 15'd25821, 15'd26386, 15'd26964, 15'd27554,
		15'd28158, 15'd28774, 15'd29405, 15'd30048, 15'd30706, 15'd31379, 15'd32066,
		15'd32767};

endpackage

/* src/cgd_if.sv */
// ============================================================================
// cgd_if - CELP gain decoder channel interfaces
// Sample channel and gain result channel, valid/ready handshake.
// ============================================================================
interface cgd_sample_if;
	logic                valid;
	logic                ready;
	logic                kind;
	cgd_pkg::s16_t       code_sample;
	logic                last_sample;
	logic [2:0]          index_a;
	logic [3:0]          index_b;

	modport source (output valid, kind, code_sample, last_sample, index_a, index_b,
		input ready);
	modport sink (input valid, kind, code_sample, last_sample, index_a, index_b,
		output ready);
endinterface

interface cgd_gain_if;
	logic                valid;
	logic                ready;
	cgd_pkg::s16_t       pitch_gain;
	cgd_pkg::u15_t       gain_mantissa;
	cgd_pkg::s8_t        gain_exponent;

	modport source (output valid, pitch_gain, gain_mantissa, gain_exponent, input ready);
	modport sink (input valid, pitch_gain, gain_mantissa, gain_exponent, output ready);
endinterface

/* src/celp_gain_decoder_core.sv */
// ============================================================================
// celp_gain_decoder_core - CELP pitch and fixed-codebook gain decoder
// Sums sample energy, then decodes both gains of a subframe with MA
// prediction on one shared multiplier under a sequencer.
// ============================================================================
//
//   channel     dir   beat carries
//   sample_ch   in    kind, code_sample, last_sample, index_a, index_b
//   gain_ch     out   pitch_gain, gain_mantissa, gain_exponent
//
// Plain samples and erasure beats are taken back to back while idle.
// A last sample starts the decode; no beats are taken until it is done.
// Energy and gain factor are normalized one bit per cycle (up to 29
// shifts, and 15 to 20), the mantissa likewise (up to 14 shifts);
// all products run on one multiplier.
// A zero-energy subframe gives a zero mantissa and exponent. arst_n clears history to -14336.
// A result waiting on gain_ch does not stop sample beats; a next decode waits to issue its result.
//
module celp_gain_decoder_core (
	input  logic               clk,
	input  logic               arst_n,
	cgd_sample_if.sink         sample_ch,
	cgd_gain_if.source         gain_ch
);

	typedef enum logic [4:0] {
		S_IDLE, S_ACC, S_CHK, S_NRM, S_LOGR, S_FRM, S_IPM,
		S_MA0, S_MA1, S_MA2, S_MA3, S_MA4, S_L2M, S_P2, S_P2M,
		S_P3, S_P3M, S_P4, S_NRMQ, S_PEM, S_PER, S_OUT
	} state_t;

	state_t              state_q;
	logic [30:0]         energy_q;
	logic                pend_q;
	cgd_pkg::s16_t       hist_q [4];
	cgd_pkg::s16_t       gp_q;
	logic signed [16:0]  gamma_q;
	logic [30:0]         ec_q;
	logic [30:0]         norm_q;
	logic [4:0]          sh_q;
	logic                ph_q;
	cgd_pkg::u15_t       fr_q;
	logic signed [20:0]  l_q;
	cgd_pkg::mul_p_t     acc_q;
	logic signed [16:0]  ip2_q;
	cgd_pkg::u15_t       fr2_q;
	cgd_pkg::u15_t       gc0_q;
	cgd_pkg::u15_t       mant_q;
	cgd_pkg::s8_t        ex_q;
	logic                out_valid_q;
	cgd_pkg::s16_t       out_gp_q;
	cgd_pkg::u15_t       out_mant_q;
	cgd_pkg::s8_t        out_ex_q;

	cgd_pkg::mul_a_t     mul_a;
	cgd_pkg::mul_b_t     mul_b;
	cgd_pkg::mul_p_t     prod_q;

	logic                in_acc;
	logic [31:0]         sq;
	logic [31:0]         esum;
	logic [30:0]         energy_add;
	logic [30:0]         e2;
	logic signed [16:0]  gp_sum;
	cgd_pkg::s16_t       gp_c;
	logic signed [16:0]  gamma_c;
	logic [4:0]          lg_idx;
	cgd_pkg::u15_t       lg_t0;
	cgd_pkg::u15_t       lg_t1;
	cgd_pkg::u15_t       lg_fr;
	logic signed [5:0]   l_ip;
	logic [4:0]          p_idx;
	cgd_pkg::u15_t       p_t0;
	cgd_pkg::u15_t       p_t1;
	logic [19:0]         p_rnd;
	logic [17:0]         base;
	logic signed [16:0]  qsh;
	logic signed [16:0]  qneg;
	logic [32:0]         q_wide;
	logic [17:0]         q_narrow;
	cgd_pkg::u15_t       q1_c;
	cgd_pkg::mul_p_t     pe_v;
	cgd_pkg::s16_t       pe_c;
	logic signed [17:0]  hsum;
	logic signed [16:0]  er_u;
	cgd_pkg::s16_t       er_c;
	logic                push_en;
	cgd_pkg::s16_t       push_val;

	assign in_acc        = sample_ch.valid && sample_ch.ready;
	assign sample_ch.ready = (state_q == S_IDLE);
	assign gain_ch.valid = out_valid_q;
	assign gain_ch.pitch_gain    = out_gp_q;
	assign gain_ch.gain_mantissa = out_mant_q;
	assign gain_ch.gain_exponent = out_ex_q;

	// shared multiplier
	cgd_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod_q)
	);

	// energy: square of the previous beat, full-scale sample clipped
	assign sq = (prod_q == 40'sd1073741824) ? 32'h3FFF_FFFF : prod_q[31:0];
	assign esum = {1'b0, energy_q} + sq;
	assign energy_add = (esum > {1'b0, cgd_pkg::ENERGY_MAX}) ? cgd_pkg::ENERGY_MAX
		: esum[30:0];
	assign e2 = (ec_q > 31'h3FFF_FFFF) ? 31'h7FFF_FFFF : {ec_q[29:0], 1'b0};

	// codebook lookup
	assign gp_sum = 17'(cgd_pkg::STAGE1_GP[cgd_pkg::MAP_A[sample_ch.index_a]])
		+ 17'(cgd_pkg::STAGE2_GP[cgd_pkg::MAP_B[sample_ch.index_b]]);
	assign gp_c = (gp_sum > 17'sd32767) ? 16'sh7FFF
		: (gp_sum < -17'sd32768) ? 16'sh8000 : gp_sum[15:0];
	assign gamma_c = 17'(cgd_pkg::STAGE1_GC[cgd_pkg::MAP_A[sample_ch.index_a]])
		+ 17'(cgd_pkg::STAGE2_GC[cgd_pkg::MAP_B[sample_ch.index_b]]);

	// log2 table segment
	assign lg_idx = norm_q[29:25];
	assign lg_t0  = cgd_pkg::LOG2_LUT[{1'b0, lg_idx}];
	assign lg_t1  = cgd_pkg::LOG2_LUT[{1'b0, lg_idx} + 6'd1];
	assign lg_fr  = lg_t0 + prod_q[29:15];
	assign l_ip   = 6'sd17 - $signed({1'b0, sh_q});

	// pow2 table segment
	assign p_idx = fr2_q[14:10];
	assign p_t0  = cgd_pkg::POW2_LUT[{1'b0, p_idx}];
	assign p_t1  = cgd_pkg::POW2_LUT[{1'b0, p_idx} + 6'd1];
	assign p_rnd = prod_q[19:0] + 20'd512;

	// scale base gain by 2^(ip2-13) and saturate to Q1
	assign base = prod_q[29:12];
	assign qsh  = ip2_q - 17'sd13;
	assign qneg = 17'sd0 - qsh;
	assign q_wide = {15'd0, base} << qsh[3:0];
	assign q_narrow = base >> qneg[4:0];
	always_comb begin
		q1_c = '0;
		if (qsh >= 17'sd0) begin
			if (qsh >= 17'sd16) begin
				q1_c = (base != '0) ? cgd_pkg::Q1_MAX : '0;
			end else begin
				q1_c = (q_wide > 33'd32767) ? cgd_pkg::Q1_MAX : q_wide[14:0];
			end
		end else if (qneg < 17'sd18) begin
			q1_c = (q_narrow > 18'd32767) ? cgd_pkg::Q1_MAX : q_narrow[14:0];
		end
	end

	// predicted error in dB, clamped to 16 bits
	assign pe_v = prod_q >>> 15;
	assign pe_c = (pe_v > 40'sd32767) ? 16'sh7FFF
		: (pe_v < -40'sd32768) ? 16'sh8000 : pe_v[15:0];

	// erasure: decayed mean of history, clamped below
	assign hsum = 18'(hist_q[0]) + 18'(hist_q[1]) + 18'(hist_q[2]) + 18'(hist_q[3]);
	assign er_u = $signed({hsum[17], hsum[17:2]}) - cgd_pkg::ERASE_DECAY;
	assign er_c = (er_u < 17'(cgd_pkg::ERR_DEFAULT)) ? cgd_pkg::ERR_DEFAULT : er_u[15:0];

	// history push select
	always_comb begin
		push_en  = 1'b0;
		push_val = cgd_pkg::ERR_DEFAULT;
		if (in_acc && sample_ch.kind) begin
			push_en  = 1'b1;
			push_val = er_c;
		end else if (state_q == S_CHK && (ec_q == '0 || gamma_q <= 17'sd0)) begin
			push_en  = 1'b1;
		end else if (state_q == S_PER) begin
			push_en  = 1'b1;
			push_val = pe_c;
		end
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_IDLE: begin
				mul_a = 24'(sample_ch.code_sample);
				mul_b = sample_ch.code_sample;
			end
			S_NRM: begin
				mul_a = {9'd0, lg_t1 - lg_t0};
				mul_b = {1'b0, norm_q[24:10]};
			end
			S_FRM: begin
				mul_a = {9'd0, fr_q};
				mul_b = cgd_pkg::NEG_DB_LOG2;
			end
			S_IPM: begin
				mul_a = {19'd0, 5'd30 - sh_q};
				mul_b = cgd_pkg::DB_PER_LOG2;
			end
			S_MA0: begin
				mul_a = 24'(hist_q[0]);
				mul_b = cgd_pkg::MA_COEF[0];
			end
			S_MA1: begin
				mul_a = 24'(hist_q[1]);
				mul_b = cgd_pkg::MA_COEF[1];
			end
			S_MA2: begin
				mul_a = 24'(hist_q[2]);
				mul_b = cgd_pkg::MA_COEF[2];
			end
			S_MA3: begin
				mul_a = 24'(hist_q[3]);
				mul_b = cgd_pkg::MA_COEF[3];
			end
			S_L2M: begin
				mul_a = acc_q[39:16];
				mul_b = cgd_pkg::INV_DB_SCALE;
			end
			S_P2M: begin
				mul_a = {9'd0, p_t1 - p_t0};
				mul_b = {6'd0, fr2_q[9:0]};
			end
			S_P3M: begin
				mul_a = {{8{gamma_q[16]}}, gamma_q[16:1]};
				mul_b = {1'b0, gc0_q};
			end
			S_PEM: begin
				mul_a = {{5{l_q[20]}}, l_q[20:2]};
				mul_b = cgd_pkg::DB_PER_LOG2;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			energy_q    <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			hist_q      <= '{default: cgd_pkg::ERR_DEFAULT};
		end else begin
			if (push_en) begin
				hist_q[3] <= hist_q[2];
				hist_q[2] <= hist_q[1];
				hist_q[1] <= hist_q[0];
				hist_q[0] <= push_val;
			end
			// output slot drains here; S_OUT refills it itself
			if (gain_ch.valid && gain_ch.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (sample_ch.kind) begin
							energy_q <= '0;
							pend_q   <= 1'b0;
						end else begin
							energy_q <= pend_q ? energy_add : energy_q;
							pend_q   <= 1'b1;
							if (sample_ch.last_sample) begin
								gp_q    <= gp_c;
								gamma_q <= gamma_c;
								state_q <= S_ACC;
							end
						end
					end else if (pend_q) begin
						energy_q <= energy_add;
						pend_q   <= 1'b0;
					end
				end
				S_ACC: begin
					ec_q     <= energy_add;
					energy_q <= '0;
					pend_q   <= 1'b0;
					state_q  <= S_CHK;
				end
				S_CHK: begin
					if (ec_q == '0 || gamma_q <= 17'sd0) begin
						mant_q  <= '0;
						ex_q    <= '0;
						state_q <= S_OUT;
					end else begin
						norm_q  <= e2;
						sh_q    <= '0;
						ph_q    <= 1'b0;
						state_q <= S_NRM;
					end
				end
				S_NRM: begin
					if (!norm_q[30]) begin
						norm_q <= {norm_q[29:0], 1'b0};
						sh_q   <= sh_q + 5'd1;
					end else begin
						state_q <= S_LOGR;
					end
				end
				S_LOGR: begin
					if (!ph_q) begin
						fr_q    <= lg_fr;
						state_q <= S_FRM;
					end else begin
						l_q     <= $signed({l_ip, lg_fr});
						state_q <= S_PEM;
					end
				end
				S_FRM: state_q <= S_IPM;
				S_IPM: begin
					acc_q   <= (prod_q >>> 15) <<< 1;
					state_q <= S_MA0;
				end
				S_MA0: begin
					acc_q   <= (acc_q + cgd_pkg::EC_BAR_BIAS - (prod_q <<< 1)) <<< 10;
					state_q <= S_MA1;
				end
				S_MA1: begin
					acc_q   <= acc_q + (prod_q <<< 1);
					state_q <= S_MA2;
				end
				S_MA2: begin
					acc_q   <= acc_q + (prod_q <<< 1);
					state_q <= S_MA3;
				end
				S_MA3: begin
					acc_q   <= acc_q + (prod_q <<< 1);
					state_q <= S_MA4;
				end
				S_MA4: begin
					acc_q   <= acc_q + (prod_q <<< 1);
					state_q <= S_L2M;
				end
				S_L2M: state_q <= S_P2;
				S_P2: begin
					ip2_q   <= prod_q[39:23];
					fr2_q   <= prod_q[22:8];
					state_q <= S_P2M;
				end
				S_P2M: state_q <= S_P3;
				S_P3: begin
					gc0_q   <= p_t0 + {5'd0, p_rnd[19:10]};
					state_q <= S_P3M;
				end
				S_P3M: state_q <= S_P4;
				S_P4: begin
					if (q1_c == '0) begin
						mant_q  <= '0;
						ex_q    <= '0;
						norm_q  <= {15'd0, gamma_q[15:0]};
						sh_q    <= '0;
						ph_q    <= 1'b1;
						state_q <= S_NRM;
					end else begin
						mant_q  <= q1_c;
						ex_q    <= 8'sd13;
						state_q <= S_NRMQ;
					end
				end
				S_NRMQ: begin
					if (!mant_q[14]) begin
						mant_q <= {mant_q[13:0], 1'b0};
						ex_q   <= ex_q - 8'sd1;
					end else begin
						norm_q  <= {15'd0, gamma_q[15:0]};
						sh_q    <= '0;
						ph_q    <= 1'b1;
						state_q <= S_NRM;
					end
				end
				S_PEM: state_q <= S_PER;
				S_PER: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q || gain_ch.ready) begin
						out_gp_q    <= gp_q;
						out_mant_q  <= mant_q;
						out_ex_q    <= ex_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_mant_norm: assert property (@(posedge clk) disable iff (!arst_n)
		gain_ch.valid |-> (gain_ch.gain_mantissa[14]
		|| (gain_ch.gain_mantissa == '0 && gain_ch.gain_exponent == '0)))
		else $error("gain mantissa not normalized");

	a_erase_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && sample_ch.kind) |=> !$rose(gain_ch.valid))
		else $error("erasure beat produced a result");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !sample_ch.kind && sample_ch.last_sample) |=> !sample_ch.ready)
		else $error("ready after last sample");

	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NRM) |-> (sh_q <= 5'd30))
		else $error("normalize shift count overrun");

	a_mant_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NRMQ) |-> (mant_q != '0))
		else $error("normalizing a zero mantissa");

endmodule

/* src/cgd_mul.sv */
// ============================================================================
// cgd_mul - shared signed multiplier
// 24 x 16 signed multiply with a registered 40-bit product.
// ============================================================================
module cgd_mul (
	input  logic            clk,
	input  cgd_pkg::mul_a_t a,
	input  cgd_pkg::mul_b_t b,
	output cgd_pkg::mul_p_t p
);

	cgd_pkg::mul_p_t p_q;

	// product register
	always_ff @(posedge clk) begin
		p_q <= 40'(a) * 40'(b);
	end

	assign p = p_q;

endmodule
